// ----- sv/rph_pkg.sv -----
// shared types, constants and id canonicalization for the packet id history
// no dependencies
`timescale 1ns / 1ps

package rph_pkg;

    localparam int ID_W  = 48;
    localparam int CAP_W = 5;
    localparam int CHAR_COUNT = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] packet_id;
    } t_in_word;

    typedef struct packed {
        logic present;
        logic evicted;
    } t_out_word;

    // string end: clear every byte after the first zero byte
    function automatic logic [ID_W-1:0] canon_id(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] r;
        logic            stop;
        r    = '0;
        stop = 1'b0;
        for (int b = CHAR_COUNT - 1; b >= 0; b--) begin
            if (v[b*8 +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[b*8 +: 8] = v[b*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/rph_ram.sv -----
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module rph_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/recent_packet_id_history.sv -----
// top level of the recent packet id history, a fifo-replaced id cache
// depends on rph_pkg and rph_ram
`timescale 1ns / 1ps

// Each word records a packet id or asks whether one is held. A record passes
// through an evict state and then a write state, which registers its result
// strobe. A query walks the single read port of the id ram one entry per
// cycle from the oldest slot over every held entry; a query on an empty
// history answers straight from idle. busy is high while a word is in work;
// a result is shown for exactly one cycle on o_word with o_strobe and cannot
// be held off. The capacity register may be written whenever busy is low. No
// clearing pass follows reset: entries are only read after being written.
module recent_packet_id_history #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rph_pkg::t_in_word     i_word,
    output logic                  o_strobe,
    output rph_pkg::t_out_word    o_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [rph_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > rph_pkg::CAP_W) ? CNT_W : rph_pkg::CAP_W;

    localparam logic [CMP_W-1:0] DEPTH_X   = CMP_W'(HISTORY_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REC_EVICT,
        ST_REC_WRITE,
        ST_SCAN
    } t_state;

    t_state                    r_state;
    logic [rph_pkg::CAP_W-1:0] r_cap;
    logic [PTR_W-1:0]          r_oldest;
    logic [CNT_W-1:0]          r_held;
    logic [rph_pkg::ID_W-1:0]  r_id;
    logic [CNT_W-1:0]          r_idx;
    logic [PTR_W-1:0]          r_rd_slot;
    logic                      r_rd_vld;
    logic                      r_hit;
    logic                      r_evicted;
    logic                      r_strobe;
    rph_pkg::t_out_word        r_out;

    logic [CMP_W-1:0]          held_x;
    logic [CMP_W-1:0]          cap_x;
    logic [CMP_W-1:0]          cap_eff;
    logic                      full;
    logic [CNT_W-1:0]          drop;
    logic [SUM_W-1:0]          osum;
    logic [SUM_W-1:0]          wsum;
    logic [PTR_W-1:0]          n_oldest;
    logic [CNT_W-1:0]          n_held;
    logic [PTR_W-1:0]          wr_slot;
    logic [PTR_W-1:0]          n_rd_slot;
    logic                      issue;
    logic                      hit_now;
    logic [rph_pkg::ID_W-1:0]  rd_data;

    always_comb begin
        held_x = CMP_W'(r_held);
        cap_x  = CMP_W'(r_cap);
        priority if (cap_x == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_x > DEPTH_X) begin
            cap_eff = DEPTH_X;
        end else begin
            cap_eff = cap_x;
        end
        full = (held_x >= cap_eff);
        drop = CNT_W'(held_x - cap_eff + CMP_W'(1));
        n_held = CNT_W'(cap_eff - CMP_W'(1));

        osum = SUM_W'(r_oldest) + SUM_W'(drop);
        n_oldest = (osum >= DEPTH_S) ? PTR_W'(osum - DEPTH_S) : PTR_W'(osum);

        wsum = SUM_W'(r_oldest) + SUM_W'(r_held);
        wr_slot = (wsum >= DEPTH_S) ? PTR_W'(wsum - DEPTH_S) : PTR_W'(wsum);

        n_rd_slot = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + PTR_W'(1);
        issue   = (r_state == ST_SCAN) && (r_idx != r_held);
        hit_now = r_rd_vld && (rd_data == r_id);
    end

    rph_ram #(
        .WIDTH (rph_pkg::ID_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_REC_WRITE),
        .i_waddr (wr_slot),
        .i_wdata (r_id),
        .i_re    (issue),
        .i_raddr (r_rd_slot),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cap    <= rph_pkg::CAP_RESET;
            r_oldest <= '0;
            r_held   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_rd_vld <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_id <= rph_pkg::canon_id(i_word.packet_id);
                        if (i_word.kind == rph_pkg::KIND_RECORD) begin
                            r_state <= ST_REC_EVICT;
                        end else if (r_held == '0) begin
                            r_strobe      <= 1'b1;
                            r_out.present <= 1'b0;
                            r_out.evicted <= 1'b0;
                        end else begin
                            r_state   <= ST_SCAN;
                            r_idx     <= '0;
                            r_rd_slot <= r_oldest;
                            r_hit     <= 1'b0;
                        end
                    end
                end
                ST_REC_EVICT: begin
                    if (full) begin
                        r_oldest  <= n_oldest;
                        r_held    <= n_held;
                        r_evicted <= 1'b1;
                    end else begin
                        r_evicted <= 1'b0;
                    end
                    r_state <= ST_REC_WRITE;
                end
                ST_REC_WRITE: begin
                    r_held        <= r_held + CNT_W'(1);
                    r_strobe      <= 1'b1;
                    r_out.present <= 1'b0;
                    r_out.evicted <= r_evicted;
                    r_state       <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (hit_now) begin
                        r_hit <= 1'b1;
                    end
                    if (issue) begin
                        r_idx     <= r_idx + CNT_W'(1);
                        r_rd_slot <= n_rd_slot;
                        r_rd_vld  <= 1'b1;
                    end else begin
                        r_strobe      <= 1'b1;
                        r_out.present <= r_hit || hit_now;
                        r_out.evicted <= 1'b0;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_word      = r_out;

endmodule

// ----- sv/rph_checker.sv -----
// port-level checks on the packet id history handshake and results
// depends on rph_pkg; bound to recent_packet_id_history
`timescale 1ns / 1ps

module rph_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input rph_pkg::t_out_word o_word
);

    // a result is only shown once the word is finished
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a word gives either a query answer or an eviction flag, not both
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_word.present && o_word.evicted))
        else $error("present and evicted together");

    // an accepted word either starts work or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted word lost");

    // leaving work always delivers the result
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("work ended without result");

    // no result appears out of idle without a word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_strobe)
        else $error("result without word");

endmodule

bind recent_packet_id_history rph_checker u_rph_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);

// ----- tb/recent_packet_id_history_test.sv -----
// self-checking bench for recent_packet_id_history: record and query words, capacity rewrites
// a scoreboard class predicts present/evicted per word; needs rph_pkg and the rtl only
`timescale 1ns / 1ps

module recent_packet_id_history_test;

    localparam int SLOTS       = 16;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 128;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [rph_pkg::ID_W-1:0] ALL_ONES = {rph_pkg::ID_W{1'b1}};

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    rph_pkg::t_in_word         i_word      = '0;
    logic                      o_strobe;
    rph_pkg::t_out_word        o_word;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [rph_pkg::CAP_W-1:0] i_cfg_data  = '0;

    class id_history_board;
        logic [rph_pkg::ID_W-1:0]  held_ids [SLOTS];
        int                        first_slot;
        int                        fill;
        int                        error_count;
        logic [rph_pkg::CAP_W-1:0] capacity;
        rph_pkg::t_out_word        expected_q [$];

        function new();
            first_slot  = 0;
            fill        = 0;
            error_count = 0;
            capacity    = rph_pkg::CAP_RESET;
        endfunction

        // id ends at its first zero byte
        function logic [rph_pkg::ID_W-1:0] trim_id(logic [rph_pkg::ID_W-1:0] raw);
            int len;
            len = rph_pkg::CHAR_COUNT;
            for (int k = rph_pkg::CHAR_COUNT - 1; k >= 0; k--) begin
                if (raw[rph_pkg::ID_W-1-8*k -: 8] == 8'h00) len = k;
            end
            if (len == 0) return '0;
            return raw & ~(ALL_ONES >> (8 * len));
        endfunction

        function void load_capacity(logic [rph_pkg::CAP_W-1:0] v);
            capacity = v;
        endfunction

        function void note_word(rph_pkg::t_in_word w);
            rph_pkg::t_out_word       want;
            logic [rph_pkg::ID_W-1:0] id;
            int                       room;
            int                       drop;
            want = '0;
            id   = trim_id(w.packet_id);
            if (w.kind == rph_pkg::KIND_RECORD) begin
                room = int'(capacity);
                if (room == 0) room = 1;
                if (room > SLOTS) room = SLOTS;
                if (fill >= room) begin
                    drop         = fill - room + 1;
                    first_slot   = (first_slot + drop) % SLOTS;
                    fill         = fill - drop;
                    want.evicted = 1'b1;
                end
                held_ids[(first_slot + fill) % SLOTS] = id;
                fill++;
            end else begin
                for (int i = 0; i < fill; i++) begin
                    if (held_ids[(first_slot + i) % SLOTS] == id) want.present = 1'b1;
                end
            end
            expected_q = {expected_q, want};
        endfunction

        task flag_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            error_count++;
        endtask

        task check_result(rph_pkg::t_out_word got);
            rph_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                flag_mismatch("result word with none expected");
            end else begin
                want = expected_q.pop_front();
                if (got.present !== want.present)
                    flag_mismatch($sformatf("present %b, expected %b",
                                            got.present, want.present));
                if (got.evicted !== want.evicted)
                    flag_mismatch($sformatf("evicted %b, expected %b",
                                            got.evicted, want.evicted));
            end
        endtask

        task close_out();
            while (expected_q.size() != 0) begin
                void'(expected_q.pop_front());
                flag_mismatch("expected result word never came");
            end
        endtask
    endclass

    id_history_board           board;
    logic [rph_pkg::ID_W-1:0]  recent_ids [$];
    logic [rph_pkg::CAP_W-1:0] phase_caps [PHASES];
    int                        cycles;

    recent_packet_id_history uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_strobe    (o_strobe),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.load_capacity(i_cfg_data);
            if (start && !busy) board.note_word(i_word);
            if (o_strobe) board.check_result(o_word);
        end
    end

    task automatic push_word(input logic k, input logic [rph_pkg::ID_W-1:0] id,
                             input bit idle_ok);
        start  <= 1'b1;
        i_word <= '{kind: k, packet_id: id};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (k == rph_pkg::KIND_RECORD) begin
            recent_ids = {recent_ids, id};
            if (recent_ids.size() > POOL_SIZE) void'(recent_ids.pop_front());
        end
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [rph_pkg::CAP_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [rph_pkg::ID_W-1:0] make_id();
        logic [rph_pkg::ID_W-1:0] v;
        int                       cut;
        v   = rph_pkg::ID_W'({$urandom(), $urandom()});
        cut = $urandom_range(0, rph_pkg::CHAR_COUNT - 1);
        case ($urandom_range(0, 4))
            0: ;
            1, 2, 3: begin
                for (int k = 0; k < rph_pkg::CHAR_COUNT; k++)
                    v[8*k +: 8] = 8'($urandom_range(33, 126));
                // zero byte with garbage after it, or a short zero-padded id
                if ($urandom_range(0, 2) == 1) v[rph_pkg::ID_W-1-8*cut -: 8] = 8'h00;
                else if ($urandom_range(0, 1) == 1) v = v & ~(ALL_ONES >> (8 * (cut + 1)));
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: v = '0;
                    1: v = ALL_ONES;
                    default: v[rph_pkg::ID_W-1 -: 8] = 8'h00;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [rph_pkg::ID_W-1:0] recall_id();
        logic [rph_pkg::ID_W-1:0] v;
        bit                       ended;
        v     = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        ended = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            for (int k = rph_pkg::CHAR_COUNT - 1; k >= 0; k--) begin
                if (ended) v[8*k +: 8] = 8'($urandom);
                else if (v[8*k +: 8] == 8'h00) ended = 1'b1;
            end
        end
        return v;
    endfunction

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        board = new();
        phase_caps[0] = 5'd1;
        phase_caps[1] = 5'd0;
        phase_caps[2] = 5'd31;
        phase_caps[3] = 5'd3;
        phase_caps[4] = 5'd16;
        phase_caps[5] = 5'd2;
        phase_caps[6] = 5'd17;
        phase_caps[7] = 5'd8;
        phase_caps[8] = 5'($urandom_range(4, 15));
        phase_caps[9] = 5'($urandom_range(0, 31));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset capacity
        push_word(rph_pkg::KIND_QUERY,  48'h414243444546, 1'b0);
        push_word(rph_pkg::KIND_RECORD, '0, 1'b0);
        push_word(rph_pkg::KIND_RECORD, ALL_ONES, 1'b0);
        push_word(rph_pkg::KIND_RECORD, 48'h414243007879, 1'b0);
        push_word(rph_pkg::KIND_QUERY,  48'h414243005a5a, 1'b0);
        push_word(rph_pkg::KIND_QUERY,  '0, 1'b0);
        push_word(rph_pkg::KIND_QUERY,  ALL_ONES, 1'b0);
        push_word(rph_pkg::KIND_QUERY,  48'h414244000000, 1'b0);
        push_word(rph_pkg::KIND_QUERY,  48'h00ffffffffff, 1'b0);
        for (int n = 0; n < 14; n++) begin
            push_word(rph_pkg::KIND_RECORD, 48'h50_4b_54_30_30_41 + 48'(n), 1'b0);
        end
        push_word(rph_pkg::KIND_QUERY,  '0, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 1) == 0) begin
                    if (recent_ids.size() > 0 && $urandom_range(0, 5) == 0)
                        push_word(rph_pkg::KIND_RECORD, recall_id(), p < PHASES - 1);
                    else
                        push_word(rph_pkg::KIND_RECORD, make_id(), p < PHASES - 1);
                end else begin
                    if (recent_ids.size() > 0 && $urandom_range(0, 9) < 6)
                        push_word(rph_pkg::KIND_QUERY, recall_id(), p < PHASES - 1);
                    else
                        push_word(rph_pkg::KIND_QUERY, make_id(), p < PHASES - 1);
                end
            end
            settle();
        end

        repeat (40) @(posedge i_clk);
        board.close_out();
        if (board.error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rph_pkg.sv
sv/rph_ram.sv
sv/recent_packet_id_history.sv
sv/rph_checker.sv
tb/recent_packet_id_history_test.sv
